[hdl/cfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

    localparam int FRAMES     = 256;
    localparam int OWNER_BITS = 8;
    localparam int IDX_W      = $clog2(FRAMES);
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int ENTRY_W    = OWNER_BITS + 1;

    // Command codes.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Policy codes.
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_NEXT  = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_PLACED    = 2'd0;
    localparam logic [1:0] ST_COMPACTED = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;
    localparam logic [1:0] ST_RELEASED  = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] owner;
        logic [8:0] size;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] start_frame;
        logic [8:0] moved_frames;
        logic [8:0] released_frames;
        logic [8:0] free_frames;
    } t_rsp;

    // Memory access bundle from the sequencer to the frame map.
    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

[hdl/cfa_map_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Frame map store: one write and one registered read each cycle.
module cfa_map_ram (
    input  wire logic                      i_clk,
    input  wire cfa_pkg::t_mem_req         i_req,
    output logic [cfa_pkg::ENTRY_W-1:0]    o_rd_data
);

    logic [cfa_pkg::ENTRY_W-1:0] r_mem [cfa_pkg::FRAMES];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/contiguous_frame_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Contiguous frame allocator over a map of 256 frames held in a single-port-read
// RAM. After reset the block clears the map and is not ready meanwhile. Every
// transaction is then handled by a sequencer that walks the map one frame per
// cycle through the RAM's registered read port: a release is one pass over the
// map, an allocation one search pass (next fit reads the map once, from its
// saved position round to the frame before it), plus a fill of "size" frames,
// and when the map must be compacted a further compaction pass and a clearing
// sweep of the free tail. The single read and write port of the frame map sets
// this pace. The result register is freed as soon as the result is taken.
module contiguous_frame_allocator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_data,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire cfa_pkg::t_req   i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output cfa_pkg::t_rsp        o_rsp
);

    localparam int IW = cfa_pkg::IDX_W;
    localparam int CW = cfa_pkg::CNT_W;
    localparam int EW = cfa_pkg::ENTRY_W;
    localparam int OB = cfa_pkg::OWNER_BITS;

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_REL     = 9'b000000100,
        S_SCAN    = 9'b000001000,
        S_COMPACT = 9'b000010000,
        S_CLEAR   = 9'b000100000,
        S_FILL    = 9'b001000000,
        S_DONE    = 9'b010000000,
        S_DECIDE  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [1:0]          r_policy;
    cfa_pkg::t_req       r_req;
    logic [CW-1:0]       r_free, n_free;
    logic [CW-1:0]       r_nfp, n_nfp;
    // Read address counter (one ahead of data), data index and valid.
    logic [CW-1:0]       r_ra, n_ra;
    logic [CW-1:0]       r_di, n_di;
    logic                r_dv, n_dv;
    // Run tracking.
    logic [CW-1:0]       r_run_start, n_run_start;
    logic [CW-1:0]       r_run_len, n_run_len;
    logic                r_found, n_found;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_best_len, n_best_len;
    // Length of the free run that opens the search.
    logic [CW-1:0]       r_head_len, n_head_len;
    logic                r_in_head, n_in_head;
    logic                r_seen_free, n_seen_free;
    logic [CW-1:0]       r_wr, n_wr;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_fill, n_fill;
    logic [1:0]          r_status, n_status;
    logic                r_rsp_valid, n_rsp_valid;
    cfa_pkg::t_rsp       r_rsp, n_rsp;
    cfa_pkg::t_mem_req   w_mem;
    logic [EW-1:0]       w_rd_data;
    logic                w_used;
    logic [CW-1:0]       w_phys;
    logic [CW-1:0]       w_from;
    logic [CW-1:0]       w_end_len;

    cfa_map_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_mem),
        .o_rd_data (w_rd_data)
    );

    assign w_used      = w_rd_data[EW-1];
    assign o_req_ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign w_from      = (r_policy == cfa_pkg::POL_NEXT) ? r_nfp : '0;

    // Physical frame of the scan data, wrapping for next fit.
    always_comb begin
        logic [CW:0] sum;
        sum = {1'b0, r_di} + {1'b0, w_from};
        if (sum >= (CW+1)'(cfa_pkg::FRAMES)) begin
            sum = sum - (CW+1)'(cfa_pkg::FRAMES);
        end
        w_phys = sum[CW-1:0];
    end

    // Run length including the current free frame.
    assign w_end_len = r_run_len + CW'(1);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= cfa_pkg::POL_FIRST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_data;
        end
    end

    // Sequencer.
    always_comb begin
        logic run_end;
        logic cand;
        logic [CW-1:0] chk_len;
        n_state     = r_state;
        n_free      = r_free;
        n_nfp       = r_nfp;
        n_ra        = r_ra;
        n_di        = r_di;
        n_dv        = 1'b0;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_found     = r_found;
        n_pos       = r_pos;
        n_best_len  = r_best_len;
        n_head_len  = r_head_len;
        n_in_head   = r_in_head;
        n_seen_free = r_seen_free;
        n_wr        = r_wr;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_status    = r_status;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp       = r_rsp;
        w_mem       = '0;
        run_end     = 1'b0;
        cand        = 1'b0;
        chk_len     = '0;

        unique case (r_state)
            S_INIT: begin
                w_mem.wr_en   = 1'b1;
                w_mem.wr_addr = r_ra[IW-1:0];
                n_ra          = r_ra + CW'(1);
                if (r_ra == CW'(cfa_pkg::FRAMES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_ra        = '0;
                n_run_len   = '0;
                n_found     = 1'b0;
                n_best_len  = '0;
                n_head_len  = '0;
                n_in_head   = 1'b1;
                n_seen_free = 1'b0;
                n_wr        = '0;
                n_cnt       = '0;
                if (i_req_valid && o_req_ready) begin
                    if (i_req.cmd == cfa_pkg::CMD_RELEASE) begin
                        n_state = S_REL;
                    end else if (i_req.size == '0 || i_req.size > r_free) begin
                        n_status = cfa_pkg::ST_REJECTED;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_REL: begin
                // Read every frame; free those of the tag.
                if (r_ra < CW'(cfa_pkg::FRAMES)) begin
                    w_mem.rd_en   = 1'b1;
                    w_mem.rd_addr = r_ra[IW-1:0];
                    n_ra          = r_ra + CW'(1);
                    n_dv          = 1'b1;
                    n_di          = r_ra;
                end
                if (r_dv) begin
                    if (w_used && w_rd_data[OB-1:0] == r_req.owner[OB-1:0]) begin
                        w_mem.wr_en   = 1'b1;
                        w_mem.wr_addr = r_di[IW-1:0];
                        w_mem.wr_data = '0;
                        n_cnt         = r_cnt + CW'(1);
                    end
                    if (r_di == CW'(cfa_pkg::FRAMES - 1)) begin
                        n_free   = r_free + n_cnt;
                        n_status = cfa_pkg::ST_RELEASED;
                        n_state  = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // Stream the map in search order, starting at w_from.
                if (r_ra < CW'(cfa_pkg::FRAMES)) begin
                    w_mem.rd_en = 1'b1;
                    begin
                        logic [CW:0] a;
                        a = {1'b0, r_ra} + {1'b0, w_from};
                        if (a >= (CW+1)'(cfa_pkg::FRAMES)) begin
                            a = a - (CW+1)'(cfa_pkg::FRAMES);
                        end
                        w_mem.rd_addr = a[IW-1:0];
                    end
                    n_ra = r_ra + CW'(1);
                    n_dv = 1'b1;
                    n_di = r_ra;
                end
                if (r_dv) begin
                    // A run never crosses the physical end of the map.
                    if (!w_used) begin
                        if (r_run_len == '0 || w_phys == '0) begin
                            n_run_start = w_phys;
                            n_run_len   = CW'(1);
                        end else begin
                            n_run_len = w_end_len;
                        end
                    end else begin
                        n_run_len = '0;
                    end
                    // Remember how far the opening run reaches.
                    if (r_in_head) begin
                        if (w_used) begin
                            n_in_head = 1'b0;
                        end else begin
                            n_head_len = n_run_len;
                            if (w_phys == CW'(cfa_pkg::FRAMES - 1)) begin
                                n_in_head = 1'b0;
                            end
                        end
                    end
                    run_end = !w_used || w_phys == CW'(cfa_pkg::FRAMES - 1)
                              || r_di == CW'(cfa_pkg::FRAMES - 1);
                    // Candidate check at the end of a run.
                    if (!w_used) begin
                        run_end = (w_phys == CW'(cfa_pkg::FRAMES - 1))
                                  || (r_di == CW'(cfa_pkg::FRAMES - 1));
                    end
                    // The last run of a wrapped search runs on into the opening run.
                    chk_len = n_run_len;
                    if (r_di == CW'(cfa_pkg::FRAMES - 1)
                        && w_phys != CW'(cfa_pkg::FRAMES - 1)) begin
                        chk_len = n_run_len + r_head_len;
                    end
                    if (w_used && r_run_len != '0) begin
                        cand = (r_run_len >= r_req.size[CW-1:0]);
                        if (cand && (r_policy != cfa_pkg::POL_BEST
                                     ? !r_found
                                     : (!r_found || r_run_len < r_best_len))) begin
                            n_found    = 1'b1;
                            n_pos      = r_run_start;
                            n_best_len = r_run_len;
                        end
                    end else if (!w_used && run_end) begin
                        if (chk_len >= r_req.size[CW-1:0]
                            && (r_policy != cfa_pkg::POL_BEST
                                ? !n_found && !r_found
                                : (!r_found || chk_len < r_best_len))) begin
                            n_found    = 1'b1;
                            n_pos      = n_run_start;
                            n_best_len = chk_len;
                        end
                        n_run_len = '0;
                    end
                    if (r_di == CW'(cfa_pkg::FRAMES - 1)) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_ra = '0;
                if (r_found) begin
                    n_status = cfa_pkg::ST_PLACED;
                    n_fill   = r_pos;
                    n_state  = S_FILL;
                end else begin
                    n_status = cfa_pkg::ST_COMPACTED;
                    n_state  = S_COMPACT;
                end
            end
            S_COMPACT: begin
                if (r_ra < CW'(cfa_pkg::FRAMES)) begin
                    w_mem.rd_en   = 1'b1;
                    w_mem.rd_addr = r_ra[IW-1:0];
                    n_ra          = r_ra + CW'(1);
                    n_dv          = 1'b1;
                    n_di          = r_ra;
                end
                if (r_dv) begin
                    if (!w_used) begin
                        n_seen_free = 1'b1;
                    end else begin
                        if (r_seen_free) begin
                            n_cnt = r_cnt + CW'(1);
                        end
                        w_mem.wr_en   = 1'b1;
                        w_mem.wr_addr = r_wr[IW-1:0];
                        w_mem.wr_data = w_rd_data;
                        n_wr          = r_wr + CW'(1);
                    end
                    if (r_di == CW'(cfa_pkg::FRAMES - 1)) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (r_wr == CW'(cfa_pkg::FRAMES)) begin
                    n_pos   = CW'(cfa_pkg::FRAMES) - r_free;
                    n_fill  = CW'(cfa_pkg::FRAMES) - r_free;
                    n_state = S_FILL;
                end else begin
                    w_mem.wr_en   = 1'b1;
                    w_mem.wr_addr = r_wr[IW-1:0];
                    w_mem.wr_data = '0;
                    n_wr          = r_wr + CW'(1);
                end
            end
            S_FILL: begin
                if (r_fill == r_pos + r_req.size[CW-1:0]
                    || r_fill == CW'(cfa_pkg::FRAMES)) begin
                    n_free  = r_free - r_req.size[CW-1:0];
                    n_nfp   = CW'(r_pos + r_req.size[CW-1:0]);
                    n_state = S_DONE;
                end else begin
                    w_mem.wr_en   = 1'b1;
                    w_mem.wr_addr = r_fill[IW-1:0];
                    w_mem.wr_data = {1'b1, r_req.owner[OB-1:0]};
                    n_fill        = r_fill + CW'(1);
                end
            end
            S_DONE: begin
                n_rsp_valid         = 1'b1;
                n_rsp.status        = r_status;
                n_rsp.start_frame   = (r_status == cfa_pkg::ST_PLACED
                                       || r_status == cfa_pkg::ST_COMPACTED)
                                      ? r_pos[7:0] : 8'd0;
                n_rsp.moved_frames  = (r_status == cfa_pkg::ST_COMPACTED)
                                      ? 9'(r_cnt) : 9'd0;
                n_rsp.released_frames = (r_status == cfa_pkg::ST_RELEASED)
                                        ? 9'(r_cnt) : 9'd0;
                n_rsp.free_frames   = 9'(r_free);
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_free      <= CW'(cfa_pkg::FRAMES);
            r_nfp       <= '0;
            r_ra        <= '0;
            r_dv        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_nfp       <= n_nfp;
            r_ra        <= n_ra;
            r_dv        <= n_dv;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
        r_di        <= n_di;
        r_run_start <= n_run_start;
        r_run_len   <= n_run_len;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_best_len  <= n_best_len;
        r_head_len  <= n_head_len;
        r_in_head   <= n_in_head;
        r_seen_free <= n_seen_free;
        r_wr        <= n_wr;
        r_cnt       <= n_cnt;
        r_fill      <= n_fill;
        r_status    <= n_status;
        r_rsp       <= n_rsp;
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(cfa_pkg::FRAMES))
        else $error("free count above frame count");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> (r_state == S_IDLE && !r_rsp_valid))
        else $error("ready outside idle");
    a_rsp_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_rsp_valid)
        else $error("result not raised after done");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_req_ready)
        else $error("ready during map clear");
`endif

endmodule

`default_nettype wire
